/* hdl/rtwd_pkg.sv */
// shared types and constants for the run-length tile-map row window decoder
// no dependencies; every other file of the block refers to it by scoped names
package rtwd_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int QUEUE_DEPTH       = 2;

   // configuration register indexes
   localparam logic [1:0] CSR_START_COLUMN = 2'd0;
   localparam logic [1:0] CSR_WINDOW_WIDTH = 2'd1;
   localparam logic [1:0] CSR_FILL_VALUE   = 2'd2;

   typedef struct packed {
      logic signed [15:0] code_word;
      logic               start_of_row;
   } req_type;

   typedef struct packed {
      logic [15:0] entry_value;
      logic [10:0] repeat_count;
      logic        is_fill;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [14:0] start_column;
      logic [10:0] window_width;
      logic [15:0] fill_value;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_LIT_HDR  = 2'd0,
      OP_FILL_HDR = 2'd1,
      OP_ENTRY    = 2'd2
   } op_kind_type;

   // classified request handed from front to back
   typedef struct packed {
      op_kind_type kind;
      logic        row_start;
      logic [16:0] arg;   // run length for headers, entry word for literals
   } op_type;

endpackage

/* hdl/rtwd_front.sv */
// front end: accepts code words and tags each as literal header, fill header or entry
// depends on rtwd_pkg
module rtwd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  rtwd_pkg::req_type req,
   output rtwd_pkg::op_type  op
);

   logic        expecting_ff, expecting_in;
   logic [14:0] run_ff, run_in;
   logic        exp_cur;
   logic [14:0] run_cur;
   logic [14:0] run_dec;
   logic [15:0] word;

   assign word    = req.code_word;
   assign exp_cur = req.start_of_row ? 1'b1 : expecting_ff;
   assign run_cur = req.start_of_row ? 15'd0 : run_ff;
   assign run_dec = run_cur - 15'd1;

   always_comb begin
      expecting_in = exp_cur;
      run_in       = run_cur;
      op.row_start = req.start_of_row;
      op.arg       = {1'b0, word};
      op.kind      = rtwd_pkg::OP_ENTRY;
      if (exp_cur) begin
         if (!word[15]) begin
            op.kind = rtwd_pkg::OP_LIT_HDR;
            if (word != 16'd0) begin
               expecting_in = 1'b0;
               run_in       = word[14:0];
            end
         end else begin
            // fill run length is the magnitude of the header
            op.kind = rtwd_pkg::OP_FILL_HDR;
            op.arg  = 17'h10000 - {1'b0, word};
         end
      end else begin
         run_in = run_dec;
         if (run_dec == 15'd0) begin
            expecting_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expecting_ff <= 1'b1;
         run_ff       <= '0;
      end else if (accept) begin
         expecting_ff <= expecting_in;
         run_ff       <= run_in;
      end
   end

endmodule

/* hdl/rtwd_queue.sv */
// short queue of classified requests between front and back
// depends on rtwd_pkg
module rtwd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rtwd_pkg::op_type push_op,
   input  logic             pop,
   output rtwd_pkg::op_type head_op,
   output logic             empty,
   output logic             full
);

   localparam int PtrW = (rtwd_pkg::QUEUE_DEPTH > 1) ? $clog2(rtwd_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(rtwd_pkg::QUEUE_DEPTH + 1);

   rtwd_pkg::op_type slot_ff [rtwd_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign empty   = (count_ff == CntW'(0));
   assign full    = (count_ff == CntW'(rtwd_pkg::QUEUE_DEPTH));
   assign head_op = slot_ff[rd_ptr_ff];

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
      next_ptr = (ptr == PtrW'(rtwd_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + PtrW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

/* hdl/rtwd_back.sv */
// back end: tracks row position and window, builds span and entry results
// depends on rtwd_pkg
module rtwd_back #(
   parameter int MAX_WIDTH = rtwd_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  rtwd_pkg::cfg_type cfg,
   input  logic              op_valid,
   input  rtwd_pkg::op_type  op,
   output logic              op_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtwd_pkg::rsp_type rsp
);

   logic [15:0] pos_ff, pos_in;
   logic [14:0] skip_ff, skip_in;
   logic [10:0] emitted_ff, emitted_in;
   logic        done_ff, done_in;
   logic        out_valid_ff;
   rtwd_pkg::rsp_type out_ff, out_in;
   logic        produce;

   logic [10:0] eff_w;
   logic [15:0] p;
   logic [14:0] skip_cur;
   logic [10:0] emitted_cur;
   logic        done_cur, done_any;
   logic [15:0] start16;
   logic [15:0] gap;
   logic [15:0] lo;
   logic [16:0] end_run, end_win, hi, count_raw, pos_sum;
   logic [10:0] remain, count;
   logic [10:0] emit_cnt, emit_total;

   assign eff_w = ({21'd0, cfg.window_width} > MAX_WIDTH) ? 11'(MAX_WIDTH) : cfg.window_width;

   assign p           = op.row_start ? 16'd0 : pos_ff;
   assign skip_cur    = op.row_start ? 15'd0 : skip_ff;
   assign emitted_cur = op.row_start ? 11'd0 : emitted_ff;
   assign done_cur    = op.row_start ? 1'b0 : done_ff;
   assign done_any    = done_cur || (emitted_cur >= eff_w);

   assign start16 = {1'b0, cfg.start_column};
   assign gap     = (start16 > p) ? start16 - p : 16'd0;

   // overlap of the fill run with the window
   assign lo        = (p > start16) ? p : start16;
   assign end_run   = {1'b0, p} + op.arg;
   assign end_win   = {2'b00, cfg.start_column} + {6'd0, eff_w};
   assign hi        = (end_run < end_win) ? end_run : end_win;
   assign count_raw = (hi > {1'b0, lo}) ? hi - {1'b0, lo} : 17'd0;
   assign remain    = eff_w - emitted_cur;
   assign count     = (count_raw > {6'd0, remain}) ? remain : count_raw[10:0];

   assign op_pop    = op_valid && (!out_valid_ff || !rsp_stall);
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      pos_in     = p;
      skip_in    = skip_cur;
      emitted_in = emitted_cur;
      done_in    = done_cur;
      produce    = 1'b0;
      emit_cnt   = 11'd1;
      pos_sum    = {1'b0, p} + 17'd1;
      out_in.entry_value = op.arg[15:0];
      out_in.is_fill     = 1'b0;
      unique case (op.kind)
         rtwd_pkg::OP_LIT_HDR: begin
            if (op.arg != 17'd0) begin
               skip_in = (gap > op.arg[15:0]) ? op.arg[14:0] : gap[14:0];
            end
         end
         rtwd_pkg::OP_FILL_HDR: begin
            pos_sum            = {1'b0, p} + op.arg;
            out_in.entry_value = cfg.fill_value;
            out_in.is_fill     = 1'b1;
            emit_cnt           = count;
            produce            = !done_any && (count_raw != 17'd0);
         end
         rtwd_pkg::OP_ENTRY: begin
            if (skip_cur != 15'd0) begin
               skip_in = skip_cur - 15'd1;
            end else begin
               produce = !done_any;
            end
         end
         default: begin
         end
      endcase
      if (op.kind != rtwd_pkg::OP_LIT_HDR) begin
         pos_in = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];
      end
      emit_total          = emitted_cur + emit_cnt;
      out_in.repeat_count = emit_cnt;
      out_in.last         = emit_total >= eff_w;
      if (produce) begin
         emitted_in = emit_total;
         done_in    = done_cur || out_in.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         skip_ff      <= '0;
         emitted_ff   <= '0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (op_pop) begin
            pos_ff     <= pos_in;
            skip_ff    <= skip_in;
            emitted_ff <= emitted_in;
            done_ff    <= done_in;
         end
         if (op_pop && produce) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop && produce) begin
         out_ff <= out_in;
      end
   end

endmodule

/* hdl/rle_tilemap_row_window_decoder.sv */
// run-length tile-map row decoder that emits a configured column window
// an accepted request is queued, then any span it yields goes to the output register
// throughput: one request per cycle unless stalled (one-step back end, output register)
// requests stall only when the two-entry queue between front and back is full
// reset (synchronous): config zeroed, decoder at row start, queue and output empty
module rle_tilemap_row_window_decoder #(
   parameter int MAX_WIDTH = rtwd_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rtwd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtwd_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   rtwd_pkg::cfg_type cfg_ff;
   rtwd_pkg::op_type  front_op, head_op;
   logic req_accept, q_empty, q_full, q_pop;

   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rtwd_pkg::CSR_START_COLUMN: cfg_ff.start_column <= csr_wdata[14:0];
            rtwd_pkg::CSR_WINDOW_WIDTH: cfg_ff.window_width <= csr_wdata[10:0];
            rtwd_pkg::CSR_FILL_VALUE:   cfg_ff.fill_value   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rtwd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_payload),
      .op     (front_op)
   );

   rtwd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_accept),
      .push_op (front_op),
      .pop     (q_pop),
      .head_op (head_op),
      .empty   (q_empty),
      .full    (q_full)
   );

   rtwd_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .op_valid  (!q_empty),
      .op        (head_op),
      .op_pop    (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp_payload)
   );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for rle_tilemap_row_window_decoder: directed rows, then random rows
// depends on rtwd_pkg for the request, response and register index definitions
module testbench;

   localparam int MAX_W         = rtwd_pkg::MAX_WIDTH_DEFAULT;
   localparam int PHASE_ITEMS   = 150;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 2000;

   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_QUIET,
      CHECK_SPAN
   } row_check_type;

   typedef struct {
      rtwd_pkg::req_type rq;
      row_check_type     how;
      rtwd_pkg::rsp_type span;
   } table_row_type;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   rtwd_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rtwd_pkg::rsp_type rsp_payload;
   logic              csr_wr_en   = 1'b0;
   logic [1:0]        csr_index   = rtwd_pkg::CSR_START_COLUMN;
   logic [15:0]       csr_wdata   = '0;

   rle_tilemap_row_window_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // decoder state as the predictor tracks it
   logic [14:0] cfg_start;
   logic [10:0] cfg_width;
   logic [15:0] cfg_fill;
   bit          want_header;
   logic [15:0] run_left;
   logic [15:0] skip_left;
   logic [15:0] position;
   logic [10:0] emitted;
   bit          window_full;

   rtwd_pkg::rsp_type expected_spans[$];
   table_row_type     rows[$];
   rtwd_pkg::rsp_type oldest;
   int                mismatches  = 0;
   int                phase_items = 0;
   int                idle_pct    = 0;
   int                stall_pct   = 0;
   int                hold_asks   = 0;
   int                hold_seen   = 0;
   int                hold_left   = 0;
   int                quiet       = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_row();
      want_header = 1'b1;
      run_left    = '0;
      skip_left   = '0;
      position    = '0;
      emitted     = '0;
      window_full = 1'b0;
   endfunction

   function automatic rtwd_pkg::rsp_type take_span(logic [15:0] value, int count, bit fill,
                                                   int wid);
      rtwd_pkg::rsp_type s;
      emitted = emitted + count[10:0];
      if (emitted >= wid) window_full = 1'b1;
      s.entry_value  = value;
      s.repeat_count = count[10:0];
      s.is_fill      = fill;
      s.last         = window_full;
      return s;
   endfunction

   // returns 1 when the word produces a span
   function automatic bit decode_word(input rtwd_pkg::req_type rq,
                                      output rtwd_pkg::rsp_type span);
      logic [15:0] word;
      int wid, p, len, lo, hi, end_run, end_win, cnt;
      bit done;
      word = rq.code_word;
      wid  = (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
      span = '0;
      if (rq.start_of_row) clear_row();
      done = window_full || (emitted >= wid);
      p    = position;
      if (want_header) begin
         if (!word[15]) begin
            len = word;
            if (len == 0) return 1'b0;
            skip_left   = (cfg_start > p) ? 16'(cfg_start - p) : 16'd0;
            if (skip_left > len) skip_left = 16'(len);
            run_left    = 16'(len);
            want_header = 1'b0;
            return 1'b0;
         end
         len     = 32'h10000 - word;
         lo      = (p > cfg_start) ? p : cfg_start;
         end_run = p + len;
         end_win = cfg_start + wid;
         hi      = (end_run < end_win) ? end_run : end_win;
         cnt     = (hi > lo) ? hi - lo : 0;
         position = (end_run > 'hFFFF) ? 16'hFFFF : 16'(end_run);
         if (done || cnt == 0) return 1'b0;
         if (cnt > wid - emitted) cnt = wid - emitted;
         span = take_span(cfg_fill, cnt, 1'b1, wid);
         return 1'b1;
      end
      // literal entry
      position = (p + 1 > 'hFFFF) ? 16'hFFFF : 16'(p + 1);
      if (run_left > 0) run_left = run_left - 16'd1;
      if (run_left == 0) want_header = 1'b1;
      if (skip_left > 0) begin
         skip_left = skip_left - 16'd1;
         return 1'b0;
      end
      if (done) return 1'b0;
      span = take_span(word, 1, 1'b0, wid);
      return 1'b1;
   endfunction

   function automatic void add_row(logic [15:0] word, bit sor, row_check_type how,
                                   logic [15:0] value = '0, int count = 0,
                                   bit fill = 1'b0, bit fin = 1'b0);
      table_row_type r;
      r.rq.code_word         = word;
      r.rq.start_of_row      = sor;
      r.how                  = how;
      r.span.entry_value     = value;
      r.span.repeat_count    = count[10:0];
      r.span.is_fill         = fill;
      r.span.last            = fin;
      rows.push_back(r);
   endfunction

   task automatic send_request(input rtwd_pkg::req_type rq, input row_check_type how,
                               input rtwd_pkg::rsp_type typed);
      rtwd_pkg::rsp_type span;
      bit has;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= rq;
      do @(posedge clock); while (req_stall);
      has = decode_word(rq, span);
      if (has && how == CHECK_MODEL) expected_spans.push_back(span);
      if (how == CHECK_SPAN) expected_spans.push_back(typed);
      phase_items++;
   endtask

   task automatic send_word(input logic [15:0] word, input bit sor);
      rtwd_pkg::req_type rq;
      rq.code_word    = word;
      rq.start_of_row = sor;
      send_request(rq, CHECK_MODEL, '0);
   endtask

   // sender pauses until every span is in and the pipeline has drained
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_spans.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [15:0] col, input logic [15:0] width,
                               input logic [15:0] fill);
      csr_wr_en <= 1'b1;
      csr_index <= rtwd_pkg::CSR_START_COLUMN;
      csr_wdata <= col;
      @(posedge clock);
      csr_index <= rtwd_pkg::CSR_WINDOW_WIDTH;
      csr_wdata <= width;
      @(posedge clock);
      csr_index <= rtwd_pkg::CSR_FILL_VALUE;
      csr_wdata <= fill;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_start = col[14:0];
      cfg_width = width[10:0];
      cfg_fill  = fill;
   endtask

   // mostly well-formed rows, some noise and some literal runs cut short
   task automatic random_row();
      int runs, sel, len, words;
      bit first;
      logic [15:0] hdr;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 4)) send_word(16'($urandom), $urandom_range(3) == 0);
         return;
      end
      runs  = $urandom_range(2, 10);
      first = 1'b1;
      repeat (runs) begin
         sel = $urandom_range(99);
         if (sel < 45) begin
            len = (sel < 5) ? 0 : (sel < 8) ? $urandom_range(7, 30) : $urandom_range(1, 6);
            send_word(len[15:0], first);
            words = ($urandom_range(19) == 0) ? $urandom_range(len) : len;
            repeat (words) send_word(16'($urandom), 1'b0);
         end else begin
            len = (sel < 52) ? 32768 : (sel < 62) ? $urandom_range(1, 32768)
                                                  : $urandom_range(1, 20);
            hdr = 16'(32'h10000 - len);
            send_word(hdr, first);
         end
         first = 1'b0;
      end
   endtask

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_spans.size() == 0) begin
            $display("%0t: unexpected span, expected none actual %h", $time, rsp_payload);
            mismatches++;
         end else begin
            oldest = expected_spans.pop_front();
            check_field("entry_value", oldest.entry_value, rsp_payload.entry_value);
            check_field("repeat_count", oldest.repeat_count, rsp_payload.repeat_count);
            check_field("is_fill", oldest.is_fill, rsp_payload.is_fill);
            check_field("last", oldest.last, rsp_payload.last);
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("%0t: timeout, nothing accepted for %0d cycles", $time, QUIET_LIMIT);
         $display("rle_tilemap_row_window_decoder verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      cfg_start = '0;
      cfg_width = '0;
      cfg_fill  = '0;
      clear_row();

      // empty window after reset, first word taken as a header without a start mark
      add_row(16'h0003, 1'b0, CHECK_QUIET);
      add_row(16'h7FFF, 1'b0, CHECK_QUIET);
      add_row(16'h8000, 1'b0, CHECK_QUIET);
      add_row(16'h0000, 1'b0, CHECK_QUIET);
      add_row(16'h8000, 1'b0, CHECK_QUIET);
      add_row(16'h0000, 1'b0, CHECK_QUIET);
      // window columns 2..6, fill 0xbeef
      add_row(16'h0004, 1'b1, CHECK_QUIET);
      add_row(16'h1111, 1'b0, CHECK_MODEL);
      add_row(16'h2222, 1'b0, CHECK_MODEL);
      add_row(16'hFFFF, 1'b0, CHECK_SPAN, 16'hFFFF, 1, 1'b0, 1'b0);
      add_row(16'h0000, 1'b0, CHECK_SPAN, 16'h0000, 1, 1'b0, 1'b0);
      add_row(16'h0000, 1'b0, CHECK_QUIET);
      add_row(16'hFFFE, 1'b0, CHECK_SPAN, 16'hBEEF, 2, 1'b1, 1'b0);
      add_row(16'hFF9C, 1'b0, CHECK_SPAN, 16'hBEEF, 1, 1'b1, 1'b1);
      add_row(16'h0001, 1'b0, CHECK_QUIET);
      add_row(16'h5555, 1'b0, CHECK_MODEL);
      add_row(16'h8000, 1'b0, CHECK_MODEL);
      // new row: fill ending before the window, then the most negative header
      add_row(16'hFFFF, 1'b1, CHECK_QUIET);
      add_row(16'hFFFD, 1'b0, CHECK_SPAN, 16'hBEEF, 2, 1'b1, 1'b0);
      add_row(16'h0002, 1'b0, CHECK_QUIET);
      add_row(16'hA5A5, 1'b0, CHECK_SPAN, 16'hA5A5, 1, 1'b0, 1'b0);
      add_row(16'h5A5A, 1'b0, CHECK_SPAN, 16'h5A5A, 1, 1'b0, 1'b0);
      add_row(16'h8000, 1'b0, CHECK_SPAN, 16'hBEEF, 1, 1'b1, 1'b1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < rows.size(); i++) begin
         if (i == 6) begin
            settle();
            write_window(16'd2, 16'd5, 16'hBEEF);
         end
         send_request(rows[i].rq, rows[i].how, rows[i].span);
      end

      // decoder state carries over between phases, so config also changes mid-row
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         unique case (phase)
            0: begin
               write_window(16'h8000, 16'hFFFF, 16'hFFFF);
               idle_pct = 0;  stall_pct = 0;
            end
            1: begin
               write_window(16'($urandom_range(40)), {5'h1F, 11'd0}, 16'($urandom));
               idle_pct = 75; stall_pct = 0;
            end
            2: begin
               write_window(16'($urandom_range(40)), 16'($urandom_range(1, 48)),
                            16'($urandom));
               idle_pct = 0;  stall_pct = 75;
            end
            3: begin
               write_window(16'h7FFF, 16'd1024, 16'h0000);
               idle_pct = 30; stall_pct = 30;
            end
            4: begin
               write_window(16'd0, 16'd1024, 16'($urandom));
               idle_pct = 0;  stall_pct = 0;
               hold_asks++;
            end
            default: begin
               write_window(16'($urandom_range(20)) | 16'h8000,
                            16'($urandom_range(1, 1100)) | 16'hF800, 16'($urandom));
               idle_pct = 30; stall_pct = 30;
            end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) random_row();
      end

      settle();
      if (mismatches == 0) begin
         $display("rle_tilemap_row_window_decoder verification clean");
      end else begin
         $display("rle_tilemap_row_window_decoder verification failed");
      end
      $finish;
   end

endmodule
